>>> rtl/ir_pulse_distance_transmitter_assert.svh
// Assertion macros for the IR pulse-distance transmitter RTL.
`ifndef IR_PULSE_DISTANCE_TRANSMITTER_ASSERT_SVH
`define IR_PULSE_DISTANCE_TRANSMITTER_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define IPDT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipdt same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define IPDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipdt next-cycle check failed");

`endif

>>> rtl/ipdt_pkg.sv
// Package of the IR pulse-distance transmitter: types, constants, frame packing.
package ipdt_pkg;

  // Frame length and derived widths
  localparam int unsigned FrameBits = 16;
  localparam int unsigned PosW      = $clog2(FrameBits);
  localparam logic [PosW-1:0] LastPos = PosW'(FrameBits - 1);

  // Field widths
  localparam int unsigned IdW   = 5;
  localparam int unsigned DataW = 5;
  localparam int unsigned TickW = 16;

  // Register reset values
  localparam logic [TickW-1:0] LongReset  = 16'd1600;
  localparam logic [TickW-1:0] ShortReset = 16'd800;
  localparam logic [TickW-1:0] GapReset   = 16'd3000;

  // Register indexes
  localparam logic [1:0] RegLong  = 2'd0;
  localparam logic [1:0] RegShort = 2'd1;
  localparam logic [1:0] RegGap   = 2'd2;

  // Item kinds
  localparam logic OpTick = 1'b0;
  localparam logic OpSend = 1'b1;

  // Transmit phases, one-hot
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_ON   = 4'b0010,
    PH_OFF  = 4'b0100,
    PH_GAP  = 4'b1000
  } phase_e;

  // Timing configuration as seen by the sequencer
  typedef struct packed {
    logic [TickW-1:0] long_ticks;
    logic [TickW-1:0] short_ticks;
    logic [TickW-1:0] gap_ticks;
  } cfg_t;

  // Pack id and data into a frame: start bit, id, data, id xor data
  function automatic logic [FrameBits-1:0] pack_frame(logic [IdW-1:0] id,
                                                      logic [DataW-1:0] data);
    logic [15:0]           w16;
    logic [FrameBits+15:0] wide;
    w16  = {id ^ data, data, id, 1'b1};
    wide = {{FrameBits{1'b0}}, w16};
    return wide[FrameBits-1:0];
  endfunction

endpackage

>>> rtl/ir_pulse_distance_transmitter.sv
// Top level of the IR pulse-distance frame transmitter.
// Each input item is either a one-microsecond tick (tuser = 0) or a send request
// (tuser = 1) with player id and data in tdata. Every item yields exactly one
// result item telling the LED level, busy and pending flags after it, with tlast
// set on the tick that finished the frame: its gap, or its last half if gap is 0.
// One item is taken per clock cycle: phase, tick counter and bit position update
// in combinational next-state logic writing straight into the output register,
// and a new item is taken when that register is empty or read out the same cycle.
// Timing registers sit at byte addresses 0 (long half), 4 (short half) and
// 8 (gap) of the APB port; a half length of 0 behaves as 1 tick.
module ir_pulse_distance_transmitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [4:0] player_id, [9:5] payload, rest zero
  input  logic        s_axis_tuser,   // [0] op
  // Result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] led_on, [1] busy_res, [2] pending, rest zero
  output logic        m_axis_tlast,   // frame_done
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned FB = ipdt_pkg::FrameBits;
  localparam int unsigned PW = ipdt_pkg::PosW;
  localparam int unsigned TW = ipdt_pkg::TickW;

  ipdt_pkg::cfg_t   cfg;
  ipdt_pkg::phase_e phase_q, phase_d;
  logic [FB-1:0]    frame_q, frame_d, pend_word_q, pend_word_d;
  logic [PW-1:0]    pos_q, pos_d;
  logic [TW-1:0]    tick_q, tick_d, tick_inc, limit;
  logic             pend_valid_q, pend_valid_d;
  logic             cur_bit, hit, done, accept;
  logic [FB-1:0]    req_word;
  logic             idle_send;

  logic             out_valid_q;
  logic             out_led_q, out_busy_q, out_pend_q, out_done_q;

  ipdt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Take an item when the output register is free or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign req_word = ipdt_pkg::pack_frame(s_axis_tdata[4:0], s_axis_tdata[9:5]);
  assign cur_bit  = frame_q[pos_q];

  // Pick the limit of the running half or gap
  always_comb begin
    case (phase_q)
      ipdt_pkg::PH_ON:  limit = cur_bit ? cfg.long_ticks : cfg.short_ticks;
      ipdt_pkg::PH_OFF: limit = cur_bit ? cfg.short_ticks : cfg.long_ticks;
      default:          limit = cfg.gap_ticks;
    endcase
  end

  // Advance the counter; a wrap also ends the interval
  assign tick_inc = tick_q + TW'(1);
  assign hit      = (tick_inc == '0) || (tick_inc >= limit);

  // Next state for one item
  always_comb begin
    phase_d      = phase_q;
    frame_d      = frame_q;
    pos_d        = pos_q;
    tick_d       = tick_q;
    pend_word_d  = pend_word_q;
    pend_valid_d = pend_valid_q;
    done         = 1'b0;
    if (accept) begin
      if (s_axis_tuser == ipdt_pkg::OpSend) begin
        if (phase_q == ipdt_pkg::PH_IDLE) begin
          frame_d = req_word;
          pos_d   = ipdt_pkg::LastPos;
          tick_d  = '0;
          phase_d = ipdt_pkg::PH_ON;
        end else begin
          pend_word_d  = req_word;
          pend_valid_d = 1'b1;
        end
      end else begin
        case (phase_q)
          ipdt_pkg::PH_ON: begin
            if (hit) begin
              tick_d  = '0;
              phase_d = ipdt_pkg::PH_OFF;
            end else begin
              tick_d = tick_inc;
            end
          end
          ipdt_pkg::PH_OFF: begin
            if (!hit) begin
              tick_d = tick_inc;
            end else if (pos_q != '0) begin
              tick_d  = '0;
              pos_d   = pos_q - PW'(1);
              phase_d = ipdt_pkg::PH_ON;
            end else if (cfg.gap_ticks != '0) begin
              tick_d  = '0;
              phase_d = ipdt_pkg::PH_GAP;
            end else begin
              done = 1'b1;
            end
          end
          ipdt_pkg::PH_GAP: begin
            if (hit) begin
              done = 1'b1;
            end else begin
              tick_d = tick_inc;
            end
          end
          default: ;
        endcase
        // End the frame and launch any waiting request
        if (done) begin
          tick_d = '0;
          if (pend_valid_q) begin
            pend_valid_d = 1'b0;
            frame_d      = pend_word_q;
            pos_d        = ipdt_pkg::LastPos;
            phase_d      = ipdt_pkg::PH_ON;
          end else begin
            phase_d = ipdt_pkg::PH_IDLE;
          end
        end
      end
    end
  end

  // Hold sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= ipdt_pkg::PH_IDLE;
      frame_q      <= '0;
      pos_q        <= ipdt_pkg::LastPos;
      tick_q       <= '0;
      pend_word_q  <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      frame_q      <= frame_d;
      pos_q        <= pos_d;
      tick_q       <= tick_d;
      pend_word_q  <= pend_word_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // Track output register occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Capture the result of the accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_led_q  <= (phase_d == ipdt_pkg::PH_ON);
      out_busy_q <= (phase_d != ipdt_pkg::PH_IDLE);
      out_pend_q <= pend_valid_d;
      out_done_q <= done;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_pend_q, out_busy_q, out_led_q};
  assign m_axis_tlast  = out_done_q;

  // Flag a send request taken while nothing is running
  assign idle_send = accept && (s_axis_tuser == ipdt_pkg::OpSend) &&
                     (phase_q == ipdt_pkg::PH_IDLE);

`include "ir_pulse_distance_transmitter_assert.svh"

  // A waiting request only exists while a frame is running
  `IPDT_ASSERT_SAME(a_pend_needs_busy, clk_i, rst_ni, pend_valid_q, phase_q != ipdt_pkg::PH_IDLE)
  // A finished frame always empties the pending slot
  `IPDT_ASSERT_SAME(a_done_clears_pend, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, !m_axis_tdata[2])
  // A request taken while idle starts the on half at once
  `IPDT_ASSERT_NEXT(a_idle_send_starts, clk_i, rst_ni, idle_send, phase_q == ipdt_pkg::PH_ON)

endmodule

>>> rtl/ipdt_regs.sv
// APB register block holding the bit-cell and gap timing of the transmitter.
module ipdt_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output ipdt_pkg::cfg_t  cfg_o
);

  logic [ipdt_pkg::TickW-1:0] long_q, short_q, gap_q;
  logic                       wr_en;
  logic [1:0]                 reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  // Write the addressed register; ignore addresses past the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q  <= ipdt_pkg::LongReset;
      short_q <= ipdt_pkg::ShortReset;
      gap_q   <= ipdt_pkg::GapReset;
    end else if (wr_en) begin
      case (reg_idx)
        ipdt_pkg::RegLong:  long_q  <= pwdata[ipdt_pkg::TickW-1:0];
        ipdt_pkg::RegShort: short_q <= pwdata[ipdt_pkg::TickW-1:0];
        ipdt_pkg::RegGap:   gap_q   <= pwdata[ipdt_pkg::TickW-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (reg_idx)
      ipdt_pkg::RegLong:  prdata = {16'd0, long_q};
      ipdt_pkg::RegShort: prdata = {16'd0, short_q};
      ipdt_pkg::RegGap:   prdata = {16'd0, gap_q};
      default:            prdata = 32'd0;
    endcase
  end

  assign cfg_o.long_ticks  = long_q;
  assign cfg_o.short_ticks = short_q;
  assign cfg_o.gap_ticks   = gap_q;

endmodule

>>> tb/sv/tb_ir_pulse_distance_transmitter.sv
// Self-checking testbench for the IR pulse-distance transmitter: table-driven and random items.
module tb_ir_pulse_distance_transmitter;
  timeunit 1ns;
  timeprecision 1ps;

  import ipdt_pkg::*;

  // Write target with no register behind it
  localparam logic [1:0] RegNone = 2'd3;
  localparam int unsigned ItemGoal = 1550;
  localparam int unsigned PrintCap = 40;

  // LED status of one result item
  typedef struct packed {
    logic led_on;
    logic busy;
    logic frame_done;
    logic pending;
  } led_status_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // One line of the directed table; want is used only when typed is set
  typedef struct packed {
    row_kind_e        kind;
    logic             op;
    logic [IdW-1:0]   id;
    logic [DataW-1:0] pl;
    logic [1:0]       reg_idx;
    logic [TickW-1:0] value;
    logic             typed;
    led_status_t      want;
  } stim_row_t;

  // want = {led_on, busy, frame_done, pending}
  localparam stim_row_t DirRows [24] = '{
    '{ROW_ITEM, OpTick, 5'd0,  5'd0,  RegLong,  16'd0,     1'b1, 4'b0000},
    '{ROW_ITEM, OpSend, 5'd31, 5'd0,  RegLong,  16'd0,     1'b1, 4'b1100},
    '{ROW_ITEM, OpSend, 5'd0,  5'd31, RegLong,  16'd0,     1'b1, 4'b1101},
    '{ROW_ITEM, OpSend, 5'd21, 5'd10, RegLong,  16'd0,     1'b1, 4'b1101},
    '{ROW_ITEM, OpTick, 5'd31, 5'd31, RegLong,  16'd0,     1'b1, 4'b1101},
    '{ROW_CFG,  OpTick, 5'd0,  5'd0,  RegLong,  16'd0,     1'b0, 4'b0000},
    '{ROW_CFG,  OpTick, 5'd0,  5'd0,  RegShort, 16'd0,     1'b0, 4'b0000},
    '{ROW_CFG,  OpTick, 5'd0,  5'd0,  RegGap,   16'd0,     1'b0, 4'b0000},
    '{ROW_CFG,  OpTick, 5'd0,  5'd0,  RegNone,  16'hFFFF,  1'b0, 4'b0000},
    '{ROW_ITEM, OpTick, 5'd31, 5'd31, RegLong,  16'd0,     1'b0, 4'b0000},
    '{ROW_ITEM, OpTick, 5'd31, 5'd31, RegLong,  16'd0,     1'b0, 4'b0000},
    '{ROW_ITEM, OpTick, 5'd31, 5'd31, RegLong,  16'd0,     1'b0, 4'b0000},
    '{ROW_ITEM, OpTick, 5'd31, 5'd31, RegLong,  16'd0,     1'b0, 4'b0000},
    '{ROW_ITEM, OpTick, 5'd31, 5'd31, RegLong,  16'd0,     1'b0, 4'b0000},
    '{ROW_ITEM, OpTick, 5'd31, 5'd31, RegLong,  16'd0,     1'b0, 4'b0000},
    '{ROW_ITEM, OpTick, 5'd31, 5'd31, RegLong,  16'd0,     1'b0, 4'b0000},
    '{ROW_ITEM, OpTick, 5'd31, 5'd31, RegLong,  16'd0,     1'b0, 4'b0000},
    '{ROW_CFG,  OpTick, 5'd0,  5'd0,  RegLong,  16'hFFFF,  1'b0, 4'b0000},
    '{ROW_CFG,  OpTick, 5'd0,  5'd0,  RegShort, 16'hFFFF,  1'b0, 4'b0000},
    '{ROW_CFG,  OpTick, 5'd0,  5'd0,  RegGap,   16'hFFFF,  1'b0, 4'b0000},
    '{ROW_ITEM, OpTick, 5'd0,  5'd0,  RegLong,  16'd0,     1'b0, 4'b0000},
    '{ROW_ITEM, OpSend, 5'd10, 5'd21, RegLong,  16'd0,     1'b0, 4'b0000},
    '{ROW_ITEM, OpTick, 5'd31, 5'd0,  RegLong,  16'd0,     1'b0, 4'b0000},
    '{ROW_ITEM, OpTick, 5'd0,  5'd31, RegLong,  16'd0,     1'b0, 4'b0000}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Timing registers as the transmitter should see them
  logic [TickW-1:0]     cfg_long  = LongReset;
  logic [TickW-1:0]     cfg_short = ShortReset;
  logic [TickW-1:0]     cfg_gap   = GapReset;

  // Transmitter state tracked by the predictor
  logic [FrameBits-1:0] frame_bits = '0;
  logic [PosW-1:0]      bit_pos    = LastPos;
  phase_e               ph         = PH_IDLE;
  logic [TickW-1:0]     tick_cnt   = '0;
  logic [FrameBits-1:0] held_word  = '0;
  logic                 held_vld   = 1'b0;

  led_status_t status_q [$];

  logic        steady = 1'b0;
  int unsigned n_errors = 0;
  int unsigned n_items = 0;
  int unsigned n_sends = 0;
  int unsigned n_frames = 0;
  int unsigned n_settings = 0;

  ir_pulse_distance_transmitter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("ir_pulse_distance_transmitter verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    n_errors++;
    if (n_errors <= PrintCap)
      $display("MISMATCH @%0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // Count one tick of the running half or gap; true once the limit is met
  function automatic logic count_tick(input logic [TickW-1:0] lim);
    tick_cnt = tick_cnt + 1'b1;
    return (tick_cnt == '0) || (tick_cnt >= lim);
  endfunction

  function automatic void load_frame(input logic [FrameBits-1:0] word);
    frame_bits = word;
    bit_pos    = LastPos;
    tick_cnt   = '0;
    ph         = PH_ON;
  endfunction

  // Finish the frame and pull in a waiting request if there is one
  function automatic void close_frame();
    tick_cnt = '0;
    n_frames++;
    if (held_vld) begin
      held_vld = 1'b0;
      load_frame(held_word);
    end else begin
      ph = PH_IDLE;
    end
  endfunction

  // Advance the transmitter by one item and give the status that follows
  task automatic advance_transmitter(input logic op, input logic [IdW-1:0] id,
                                     input logic [DataW-1:0] pl,
                                     output led_status_t st);
    logic [FrameBits-1:0] word;
    logic                 one_bit;
    logic                 done;
    word    = {id ^ pl, pl, id, 1'b1};
    one_bit = frame_bits[bit_pos];
    done    = 1'b0;
    if (op == OpSend) begin
      if (ph == PH_IDLE) begin
        load_frame(word);
      end else begin
        held_word = word;
        held_vld  = 1'b1;
      end
    end else begin
      case (ph)
        PH_ON: begin
          if (count_tick(one_bit ? cfg_long : cfg_short)) begin
            tick_cnt = '0;
            ph       = PH_OFF;
          end
        end
        PH_OFF: begin
          if (count_tick(one_bit ? cfg_short : cfg_long)) begin
            tick_cnt = '0;
            if (bit_pos == '0) begin
              if (cfg_gap == '0) begin
                close_frame();
                done = 1'b1;
              end else begin
                ph = PH_GAP;
              end
            end else begin
              bit_pos = bit_pos - 1'b1;
              ph      = PH_ON;
            end
          end
        end
        PH_GAP: begin
          if (count_tick(cfg_gap)) begin
            close_frame();
            done = 1'b1;
          end
        end
        default: ;
      endcase
    end
    st.led_on     = (ph == PH_ON);
    st.busy       = (ph != PH_IDLE);
    st.frame_done = done;
    st.pending    = held_vld;
  endtask

  // Present one item after a random gap and log its expected status
  task automatic drive_item(input logic op, input logic [IdW-1:0] id,
                            input logic [DataW-1:0] pl, input logic typed,
                            input led_status_t want);
    int unsigned idle;
    led_status_t pred;
    idle = steady ? 0 : $urandom_range(0, 11);
    @(negedge clk_i);
    if (idle != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(16 - IdW - DataW){1'b0}}, pl, id};
    do @(posedge clk_i); while (!s_axis_tready);
    advance_transmitter(op, id, pl, pred);
    status_q.push_back(typed ? want : pred);
    n_items++;
    if (op == OpSend) n_sends++;
  endtask

  // Hold the sender until every result is back and the output has drained
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write a timing register, then read it back unless no register is behind it
  task automatic write_timing(input logic [1:0] idx, input logic [TickW-1:0] value);
    logic [31:0]      got;
    logic [TickW-1:0] want;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom_range(0, 65535)), value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegLong:  cfg_long  = value;
      RegShort: cfg_short = value;
      RegGap:   cfg_gap   = value;
      default:  ;
    endcase
    if (idx != RegNone) begin
      n_settings++;
      want = (idx == RegLong) ? cfg_long : (idx == RegShort) ? cfg_short : cfg_gap;
      @(negedge clk_i);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      got = prdata;
      if (got !== {16'b0, want}) report_mismatch("register readback", got, want);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result side: random back-pressure, check each accepted item in order
  initial begin
    led_status_t want;
    int unsigned hold;
    m_axis_tready = 1'b0;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (status_q.size() == 0) begin
          report_mismatch("result with nothing expected", 1, 0);
        end else begin
          want = status_q.pop_front();
          if (m_axis_tdata[0] !== want.led_on)
            report_mismatch("led_on", m_axis_tdata[0], want.led_on);
          if (m_axis_tdata[1] !== want.busy)
            report_mismatch("busy", m_axis_tdata[1], want.busy);
          if (m_axis_tdata[2] !== want.pending)
            report_mismatch("pending", m_axis_tdata[2], want.pending);
          if (m_axis_tlast !== want.frame_done)
            report_mismatch("frame_done", m_axis_tlast, want.frame_done);
        end
        hold = steady ? 0 : $urandom_range(0, 11);
      end
      @(negedge clk_i);
      if (hold != 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Stimulus: reset, directed table, then random timing phases
  initial begin
    stim_row_t   row;
    int unsigned mode;
    int unsigned span;
    logic        op;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OpTick;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rst_ni        = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    for (int i = 0; i < 24; i++) begin
      row = DirRows[i];
      if (row.kind == ROW_CFG) begin
        settle();
        write_timing(row.reg_idx, row.value);
      end else begin
        drive_item(row.op, row.id, row.pl, row.typed, row.want);
      end
    end

    // Random phases: new timing each phase, mostly whole frames
    while (n_items < ItemGoal) begin
      settle();
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        write_timing(RegLong, 16'hFFFF);
        write_timing(RegShort, 16'hFFFF);
        write_timing(RegGap, 16'hFFFF);
        span = 25;
      end else if (mode == 1) begin
        write_timing(RegLong, '0);
        write_timing(RegShort, '0);
        write_timing(RegGap, '0);
        span = 120;
      end else begin
        write_timing(RegLong, TickW'($urandom_range(0, 3)));
        write_timing(RegShort, TickW'($urandom_range(0, 2)));
        write_timing(RegGap, ($urandom_range(0, 2) == 0) ? '0 : TickW'($urandom_range(1, 6)));
        span = $urandom_range(60, 160);
      end
      steady = ($urandom_range(0, 3) == 0);
      repeat (span) begin
        if (ph == PH_IDLE) op = ($urandom_range(0, 3) != 0) ? OpSend : OpTick;
        else op = ($urandom_range(0, 29) == 0) ? OpSend : OpTick;
        drive_item(op, IdW'($urandom_range(0, 31)), DataW'($urandom_range(0, 31)),
                   1'b0, '0);
      end
    end

    // Drain and let the output settle
    settle();
    steady = 1'b0;
    repeat (16) @(posedge clk_i);
    $display("Sent %0d items, %0d of them send requests; %0d frames finished.",
             n_items, n_sends, n_frames);
    $display("Timing registers written %0d times, zero and full-scale values included.",
             n_settings);
    if (n_errors == 0) begin
      $display("ir_pulse_distance_transmitter verification clean");
    end else begin
      $display("ir_pulse_distance_transmitter verification failed");
    end
    $finish;
  end

endmodule
